// ----- rtl/core/button_press_classifier_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the button press classifier checks.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Check that a condition holds in the cycle after a trigger.
`define BPC_ASSERT_NEXT(name, clk, rst_n, trig, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/core/bpc_pkg.sv -----
// ---------------------------------------------------------------------------
// Button press classifier package
// Field widths, register indexes, phase and event codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned BTN_W     = 3;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_EN    = 2'd2;

  localparam logic [TICKS_W-1:0] SHORT_PRESS_RST = 16'd100;
  localparam logic [TICKS_W-1:0] MULTI_PRESS_RST = 16'd30;
  localparam logic [CFG_W-1:0]   EVENT_EN_RST    = 32'd0;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_PRESS1  = 3'd1,
    PH_REL1    = 3'd2,
    PH_PRESS2  = 3'd3,
    PH_REL2    = 3'd4,
    PH_PRESS3  = 3'd5,
    PH_REL3    = 3'd6,
    PH_LONGREL = 3'd7
  } bpc_phase_e;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } bpc_event_e;

endpackage

`default_nettype wire

// ----- rtl/core/bpc_in_if.sv -----
// ---------------------------------------------------------------------------
// Tick sample channel
// Valid/ready channel carrying one button tick sample per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if
  import bpc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_index;
  logic             pin_pressed;

  modport source (output valid, output button_index, output pin_pressed, input ready);
  modport sink   (input valid, input button_index, input pin_pressed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bpc_out_if.sv -----
// ---------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one classified event per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bpc_out_if
  import bpc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BTN_W-1:0]  event_button;
  logic [CODE_W-1:0] event_code;

  modport source (output valid, output event_button, output event_code, input ready);
  modport sink   (input valid, input event_button, input event_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bpc_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/bpc_classify.sv -----
// ---------------------------------------------------------------------------
// Press classifier step
// Next phase, next tick count and raw event for one button tick.
// ---------------------------------------------------------------------------
`default_nettype none

module bpc_classify
  import bpc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  bpc_phase_e             phase_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic                   pressed_i,
  input  logic [TICKS_W-1:0]     short_ticks_i,
  input  logic [TICKS_W-1:0]     multi_ticks_i,
  output bpc_phase_e             phase_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output bpc_event_e             code_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   below_short;
  logic                   reach_multi;

  always_comb begin
    if ((phase_i != PH_IDLE) && (count_i != {COUNT_WIDTH{1'b1}})) begin
      cnt_inc = count_i + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      cnt_inc = count_i;
    end
  end

  assign cnt_ext     = CMP_W'(cnt_inc);
  assign below_short = cnt_ext < CMP_W'(short_ticks_i);
  assign reach_multi = cnt_ext >= CMP_W'(multi_ticks_i);

  always_comb begin
    phase_o = phase_i;
    count_o = cnt_inc;
    code_o  = EV_NONE;
    case (phase_i)
      PH_IDLE: begin
        if (pressed_i) begin
          phase_o = PH_PRESS1;
          count_o = '0;
        end
      end
      PH_PRESS1: begin
        if (!pressed_i) begin
          if (below_short) begin
            phase_o = PH_REL1;
            count_o = '0;
          end else begin
            phase_o = PH_LONGREL;
          end
        end
      end
      PH_REL1, PH_REL2: begin
        if (reach_multi) begin
          code_o  = (phase_i == PH_REL1) ? EV_SINGLE : EV_DOUBLE;
          phase_o = PH_IDLE;
          count_o = '0;
        end else if (pressed_i) begin
          phase_o = (phase_i == PH_REL1) ? PH_PRESS2 : PH_PRESS3;
        end
      end
      PH_PRESS2, PH_PRESS3: begin
        if (!pressed_i) begin
          phase_o = (phase_i == PH_PRESS2) ? PH_REL2 : PH_REL3;
          count_o = '0;
        end
      end
      PH_REL3: begin
        code_o  = EV_TRIPLE;
        phase_o = PH_IDLE;
        count_o = '0;
      end
      default: begin
        code_o  = EV_LONG;
        phase_o = PH_IDLE;
        count_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/button_press_classifier_top.sv -----
// ---------------------------------------------------------------------------
// Button press classifier
// Sorts per-button tick samples into single, double, triple and long presses.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one tick sample per beat (button index, pressed level).
//   out_o carries exactly one event beat per sample: the button index and
//   an event code (0 none, 1 single, 2 double, 3 triple, 4 long).
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i, by
//   the user only while the block is idle (not enforced): 0 short press
//   ticks, 1 multi press ticks, 2 event enables (four bits per button).
//   A sample passes the input register, then the event register; one
//   sample is taken every cycle while the receiver takes events. The
//   per-button phase and count sit in a RAM read on acceptance and
//   written as the sample moves on; a bypass register covers back-to-back
//   samples for the same button. After reset every button is idle with
//   a zero count and the registers hold 100, 30 and 0. While the receiver
//   stalls, the event register holds and one further sample is taken into
//   the input register; then in_i drops ready until the event beat leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_top
  import bpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 8,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bpc_in_if.sink               in_i,
  bpc_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned DW = PHASE_W + COUNT_WIDTH;

  logic [TICKS_W-1:0]     short_q;
  logic [TICKS_W-1:0]     multi_q;
  logic [CFG_W-1:0]       enable_q;

  logic                   in_vld_q;
  logic [BTN_W-1:0]       in_idx_q;
  logic                   in_pr_q;

  logic                   out_vld_q;
  logic [BTN_W-1:0]       out_btn_q;
  logic [CODE_W-1:0]      out_code_q;

  logic [NUM_BUTTONS-1:0] written_q;
  logic                   byp_vld_q;
  logic [AW-1:0]          byp_addr_q;
  logic [DW-1:0]          byp_data_q;

  logic                   accept;
  logic                   fire;
  logic                   in_range;
  logic [AW-1:0]          addr;
  logic [DW-1:0]          ram_rdata;
  logic [DW-1:0]          cur_state;
  logic [DW-1:0]          new_state;
  bpc_phase_e             nxt_phase;
  logic [COUNT_WIDTH-1:0] nxt_count;
  bpc_event_e             raw_code;
  logic [CODE_W-1:0]      raw_bits;
  logic [CODE_W-1:0]      gated_code;

  assign fire     = in_vld_q && (!out_vld_q || out_o.ready);
  assign accept   = in_i.valid && in_i.ready;
  assign in_range = 32'(in_idx_q) < NUM_BUTTONS;
  assign addr     = AW'(in_idx_q);

  assign in_i.ready         = !in_vld_q || fire;
  assign out_o.valid        = out_vld_q;
  assign out_o.event_button = out_btn_q;
  assign out_o.event_code   = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q  <= SHORT_PRESS_RST;
      multi_q  <= MULTI_PRESS_RST;
      enable_q <= EVENT_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHORT_PRESS: short_q  <= cfg_data_i[TICKS_W-1:0];
        REG_MULTI_PRESS: multi_q  <= cfg_data_i[TICKS_W-1:0];
        REG_EVENT_EN:    enable_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_idx_q <= in_i.button_index;
      in_pr_q  <= in_i.pin_pressed;
    end
  end

  bpc_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (fire && in_range),
    .waddr_i (addr),
    .wdata_i (new_state),
    .re_i    (accept),
    .raddr_i (AW'(in_i.button_index)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (byp_vld_q && (byp_addr_q == addr)) begin
      cur_state = byp_data_q;
    end else if (written_q[addr]) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = {PH_IDLE, {COUNT_WIDTH{1'b0}}};
    end
  end

  bpc_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .phase_i       (bpc_phase_e'(cur_state[DW-1 -: PHASE_W])),
    .count_i       (cur_state[COUNT_WIDTH-1:0]),
    .pressed_i     (in_pr_q),
    .short_ticks_i (short_q),
    .multi_ticks_i (multi_q),
    .phase_o       (nxt_phase),
    .count_o       (nxt_count),
    .code_o        (raw_code)
  );

  assign new_state = {nxt_phase, nxt_count};
  assign raw_bits  = raw_code;

  always_comb begin
    gated_code = EV_NONE;
    if (in_range && (raw_code != EV_NONE)) begin
      if (enable_q[{in_idx_q, 2'(raw_bits - 3'd1)}]) begin
        gated_code = raw_bits;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      byp_vld_q <= 1'b0;
    end else if (fire && in_range) begin
      written_q[addr] <= 1'b1;
      byp_vld_q       <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_range) begin
      byp_addr_q <= addr;
      byp_data_q <= new_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_btn_q  <= in_idx_q;
      out_code_q <= gated_code;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bpc_checker.sv -----
// ---------------------------------------------------------------------------
// Button press classifier checker
// Port-level checks on flow control, latency and event codes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_top_assert.svh"

module bpc_checker
  import bpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BTN_W-1:0]  out_button,
  input logic [CODE_W-1:0] out_code
);

  `BPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
                   out_valid && $stable(out_button) && $stable(out_code))

  `BPC_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !in_ready |-> (out_valid && !out_ready))

  `BPC_ASSERT(a_two_cycle_latency, clk_i, rst_ni,
              (in_valid && in_ready) ##1 out_ready |=> out_valid)

  `BPC_ASSERT(a_no_event_out_of_range, clk_i, rst_ni,
              (out_valid && (32'(out_button) >= NUM_BUTTONS)) |-> (out_code == EV_NONE))

endmodule

bind button_press_classifier_top bpc_checker #(
  .NUM_BUTTONS (NUM_BUTTONS)
) u_bpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_button (out_o.event_button),
  .out_code   (out_o.event_code)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Button press classifier testbench
// Feeds per-button tick samples through the valid/ready input channel and
// predicts every event beat from a cycle-free model of the phase machine.
// A short directed run covers single, double, triple and long presses. It is
// followed by random press episodes under several register settings,
// threshold extremes among them, and a hold past the short press threshold
// that ends in a long press. Both channels idle and stall in random bursts.
// ---------------------------------------------------------------------------

module tb;
  import bpc_pkg::*;

  localparam int unsigned NUM_BTN     = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD   = 60;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic             pressed;
  } tick_sample_t;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    bpc_event_e       code;
  } press_event_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  bpc_in_if  tick_if ();
  bpc_out_if evt_if ();

  button_press_classifier_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (evt_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tick_sample_t tick_pending[$];
  press_event_t event_expected[$];

  bpc_phase_e       btn_phase [NUM_BTN];
  logic [TICKS_W-1:0] btn_count [NUM_BTN];
  logic [TICKS_W-1:0] cfg_short  = SHORT_PRESS_RST;
  logic [TICKS_W-1:0] cfg_multi  = MULTI_PRESS_RST;
  logic [CFG_W-1:0]   cfg_enable = EVENT_EN_RST;

  logic        tick_fire   = 1'b0;
  int unsigned ticks_taken = 0;
  int unsigned events_seen = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_odds   = 0;
  int unsigned stall_odds  = 0;
  int unsigned tick_gap    = 0;
  int unsigned evt_stall   = 0;
  int unsigned ticks_queued = 0;

  initial begin
    for (int i = 0; i < NUM_BTN; i++) begin
      btn_phase[i] = PH_IDLE;
      btn_count[i] = '0;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bpc_event_e classify_tick(logic [BTN_W-1:0] b, logic pressed);
    bpc_phase_e         ph;
    logic [TICKS_W-1:0] cnt;
    bpc_event_e         ev;
    int                 en_idx;
    ph  = btn_phase[b];
    cnt = btn_count[b];
    ev  = EV_NONE;
    if (ph != PH_IDLE && cnt != '1) cnt = cnt + 1'b1;
    case (ph)
      PH_IDLE: begin
        if (pressed) begin
          ph  = PH_PRESS1;
          cnt = '0;
        end
      end
      PH_PRESS1: begin
        if (!pressed) begin
          if (cnt < cfg_short) begin
            ph  = PH_REL1;
            cnt = '0;
          end else begin
            ph = PH_LONGREL;
          end
        end
      end
      PH_REL1, PH_REL2: begin
        if (cnt >= cfg_multi) begin
          ev  = (ph == PH_REL1) ? EV_SINGLE : EV_DOUBLE;
          ph  = PH_IDLE;
          cnt = '0;
        end else if (pressed) begin
          ph = (ph == PH_REL1) ? PH_PRESS2 : PH_PRESS3;
        end
      end
      PH_PRESS2, PH_PRESS3: begin
        if (!pressed) begin
          ph  = (ph == PH_PRESS2) ? PH_REL2 : PH_REL3;
          cnt = '0;
        end
      end
      PH_REL3: begin
        ev  = EV_TRIPLE;
        ph  = PH_IDLE;
        cnt = '0;
      end
      default: begin
        ev  = EV_LONG;
        ph  = PH_IDLE;
        cnt = '0;
      end
    endcase
    btn_phase[b] = ph;
    btn_count[b] = cnt;
    if (ev != EV_NONE) begin
      en_idx = int'(b) * 4 + int'(ev) - 1;
      if (!cfg_enable[en_idx]) ev = EV_NONE;
    end
    return ev;
  endfunction

  // sample both channels and the register port
  always @(posedge clk_i) begin : beat_monitor
    press_event_t want;
    if (rst_ni) begin
      tick_fire <= tick_if.valid && tick_if.ready;
      if (cfg_we) begin
        case (cfg_idx)
          REG_SHORT_PRESS: cfg_short  = cfg_data[TICKS_W-1:0];
          REG_MULTI_PRESS: cfg_multi  = cfg_data[TICKS_W-1:0];
          REG_EVENT_EN:    cfg_enable = cfg_data;
          default: ;
        endcase
      end
      if (evt_if.valid && evt_if.ready) begin
        events_seen <= events_seen + 1;
        if (event_expected.size() == 0) begin
          $display("%0t: unexpected event beat: button %0d code %0d", $time,
                   evt_if.event_button, evt_if.event_code);
          fail_count++;
        end else begin
          want = event_expected.pop_front();
          if (evt_if.event_button !== want.button) begin
            $display("%0t: event_button mismatch: expected %0d, actual %0d", $time,
                     want.button, evt_if.event_button);
            fail_count++;
          end
          if (evt_if.event_code !== want.code) begin
            $display("%0t: event_code mismatch on button %0d: expected %0d, actual %0d",
                     $time, want.button, want.code, evt_if.event_code);
            fail_count++;
          end
        end
      end
      if (tick_if.valid && tick_if.ready) begin
        want.button = tick_if.button_index;
        want.code   = classify_tick(tick_if.button_index, tick_if.pin_pressed);
        event_expected.push_back(want);
        ticks_taken <= ticks_taken + 1;
      end
    end
  end

  always @(negedge clk_i) begin : tick_driver
    tick_sample_t nxt;
    if (rst_ni && (!tick_if.valid || tick_fire)) begin
      if (tick_gap == 0 && $urandom_range(0, 99) < idle_odds)
        tick_gap = $urandom_range(1, 16);
      if (tick_gap > 0) begin
        tick_gap--;
        tick_if.valid <= 1'b0;
      end else if (tick_pending.size() != 0) begin
        nxt = tick_pending.pop_front();
        tick_if.valid        <= 1'b1;
        tick_if.button_index <= nxt.button;
        tick_if.pin_pressed  <= nxt.pressed;
      end else begin
        tick_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : event_sink
    if (evt_stall == 0 && $urandom_range(0, 99) < stall_odds)
      evt_stall = $urandom_range(1, 16);
    if (evt_stall > 0) begin
      evt_stall--;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic push_tick(logic [BTN_W-1:0] b, logic pressed);
    tick_sample_t s;
    s.button  = b;
    s.pressed = pressed;
    tick_pending.push_back(s);
    ticks_queued++;
  endtask

  task automatic push_pattern(logic [BTN_W-1:0] b, string levels);
    for (int i = 0; i < levels.len(); i++) push_tick(b, levels[i] == "1");
  endtask

  // hold one level on a button, with stray samples from any button mixed in
  task automatic push_held(logic [BTN_W-1:0] b, logic pressed, int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        push_tick(BTN_W'($urandom_range(0, NUM_BTN - 1)), 1'($urandom_range(0, 1)));
      push_tick(b, pressed);
    end
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned      start;
    int unsigned      s_lim;
    int unsigned      m_lim;
    logic [BTN_W-1:0] b;
    start = ticks_queued;
    s_lim = (cfg_short > 6) ? 8 : cfg_short + 2;
    m_lim = (cfg_multi > 6) ? 8 : cfg_multi + 2;
    while (ticks_queued - start < n) begin
      b = BTN_W'($urandom_range(0, NUM_BTN - 1));
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 10))
          push_tick(BTN_W'($urandom_range(0, NUM_BTN - 1)), 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          push_held(b, 1'b1, $urandom_range(1, s_lim));
          push_held(b, 1'b0, $urandom_range(1, m_lim));
        end
        push_held(b, 1'b0, m_lim + 1);
      end
    end
  endtask

  task automatic drain_events();
    do @(posedge clk_i);
    while (tick_pending.size() != 0 || tick_if.valid || ticks_taken != events_seen);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [TICKS_W-1:0] short_t, logic [TICKS_W-1:0] multi_t,
                           logic [CFG_W-1:0] enables, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned n);
    write_reg(REG_SHORT_PRESS, CFG_W'(short_t));
    write_reg(REG_MULTI_PRESS, CFG_W'(multi_t));
    write_reg(REG_EVENT_EN, enables);
    @(posedge clk_i);
    idle_odds  = idle_pct;
    stall_odds = stall_pct;
    queue_random(n);
    drain_events();
  endtask

  initial begin : stimulus
    tick_if.valid        = 1'b0;
    tick_if.button_index = '0;
    tick_if.pin_pressed  = 1'b0;
    evt_if.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;
    rst_ni               = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds, all events disabled
    @(posedge clk_i);
    idle_odds  = 20;
    stall_odds = 20;
    queue_random(40);
    drain_events();

    write_reg(REG_SHORT_PRESS, 32'd3);
    write_reg(REG_MULTI_PRESS, 32'd2);
    write_reg(REG_EVENT_EN, '1);
    write_reg(REG_UNUSED, 32'h0000_0001);
    @(posedge clk_i);
    push_pattern(3'd0, "1000");
    push_pattern(3'd1, "101000");
    push_pattern(3'd2, "1010100");
    push_pattern(3'd7, "111100");
    drain_events();

    run_phase(TICKS_W'($urandom_range(2, 6)), TICKS_W'($urandom_range(1, 4)), '1,
              25, 25, 60);
    run_phase(16'd0, 16'd0, $urandom, 10, 40, 60);
    run_phase(16'hFFFF, 16'hFFFF, '1, 0, 0, 60);
    run_phase(16'd1, 16'hFFFF, $urandom, 40, 10, 60);
    run_phase(16'hFFFF, 16'd1, $urandom, 20, 20, 60);

    // hold one button past the short press threshold
    write_reg(REG_SHORT_PRESS, 32'd40);
    write_reg(REG_MULTI_PRESS, 32'd5);
    write_reg(REG_EVENT_EN, '1);
    @(posedge clk_i);
    idle_odds  = 0;
    stall_odds = 0;
    push_held(3'd3, 1'b0, 10);
    repeat (LONG_HOLD) push_tick(3'd3, 1'b1);
    push_pattern(3'd3, "00");
    drain_events();

    run_phase(TICKS_W'($urandom_range(1, 5)), TICKS_W'($urandom_range(1, 4)), $urandom,
              0, 0, 60);

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/bpc_in_if.sv
rtl/core/bpc_out_if.sv
rtl/core/bpc_ram.sv
rtl/core/bpc_classify.sv
rtl/core/button_press_classifier_top.sv
rtl/core/bpc_checker.sv
dv/tb.sv
